// ===== rtl/rapr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rapr_pkg: shared types and constants for the roll angle regulator
// Beat payload structs, register indexes, sequencer states and step codes.
// ----------------------------------------------------------------------------
package rapr_pkg;

   // register port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   // field widths
   localparam int ANGLE_W  = 16;
   localparam int DT_W     = 16;
   localparam int GAIN_W   = 20;
   localparam int LIMIT_W  = 15;
   localparam int THRUST_W = 13;
   localparam int INTEG_W  = 48;
   localparam int DRIVE_W  = 48;

   // restoring divider: (|diff| << 20) / dt
   localparam int RATE_SHIFT = 20;
   localparam int QUO_W      = ANGLE_W + RATE_SHIFT;   // 36
   localparam int CNT_W      = 6;

   // shared multiplier: 24 x 20 bits
   localparam int MUL_A_W  = 24;
   localparam int MUL_P_W  = MUL_A_W + GAIN_W;         // 44
   localparam int ACC_W    = MUL_P_W + MUL_A_W;        // 68

   // reset values of the registers
   localparam logic [GAIN_W-1:0]   ERROR_GAIN_RST    = 20'd27118;
   localparam logic [GAIN_W-1:0]   RATE_GAIN_RST     = 20'd6531;
   localparam logic [GAIN_W-1:0]   INTEGRAL_GAIN_RST = 20'd87228;
   localparam logic [LIMIT_W-1:0]  DRIVE_LIMIT_RST   = 15'd1229;
   localparam logic [THRUST_W-1:0] THRUST_LEVEL_RST  = 13'd2048;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ERROR_GAIN    = 3'd0,
      CSR_RATE_GAIN     = 3'd1,
      CSR_INTEGRAL_GAIN = 3'd2,
      CSR_DRIVE_LIMIT   = 3'd3,
      CSR_THRUST_LEVEL  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULTIPLY
   } state_type;

   // multiply/accumulate step codes
   localparam logic [2:0] STEP_P_ISSUE  = 3'd0;
   localparam logic [2:0] STEP_R_LO     = 3'd1;
   localparam logic [2:0] STEP_R_HI     = 3'd2;
   localparam logic [2:0] STEP_I_LO     = 3'd3;
   localparam logic [2:0] STEP_I_HI     = 3'd4;
   localparam logic [2:0] STEP_INCR     = 3'd5;
   localparam logic [2:0] STEP_I_FOLD   = 3'd6;
   localparam logic [2:0] STEP_FINISH   = 3'd7;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] measured_angle;
      logic signed [ANGLE_W-1:0] target_angle;
      logic        [DT_W-1:0]    step_time;
   } req_payload_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll_drive;
      logic        [THRUST_W-1:0] thrust_drive;
   } rsp_payload_type;

endpackage
`default_nettype wire

// ===== rtl/roll_angle_pid_regulator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// roll_angle_pid_regulator_unit: PID roll regulator, derivative on measurement
// One drive beat per angle beat, computed by a bit-serial divider and one
// shared 24x20 multiplier under a step sequencer.
// ----------------------------------------------------------------------------
// The response beat is loaded once the restoring divider has formed the
// angle rate (one quotient bit per cycle) and the multiply/accumulate steps
// on the shared 24x20 multiplier have run (proportional, two rate partials,
// two integral partials, the integral increment, the integral fold, then
// clamp and integral update). The request side stalls while an item is in
// work and reopens on the edge that loads the response register, so no new
// request beat is taken until the last one's response is loaded; a waiting
// response holds the last step until it is taken. Registers may be written
// only while the block is idle.
module roll_angle_pid_regulator_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  rapr_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output rapr_pkg::rsp_payload_type           rsp_payload,
   input  wire                                 csr_write_enable,
   input  wire  [rapr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [rapr_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import rapr_pkg::*;

   // configuration registers
   logic [GAIN_W-1:0]   error_gain_ff, error_gain_in;
   logic [GAIN_W-1:0]   rate_gain_ff, rate_gain_in;
   logic [GAIN_W-1:0]   integral_gain_ff, integral_gain_in;
   logic [LIMIT_W-1:0]  drive_limit_ff, drive_limit_in;
   logic [THRUST_W-1:0] thrust_level_ff, thrust_level_in;

   // control
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]       step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // regulator state
   logic signed [ANGLE_W-1:0] prev_angle_ff, prev_angle_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;

   // per-item working registers
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic [ANGLE_W-1:0]        emag_ff, emag_in;
   logic                      eneg_ff, eneg_in;
   logic                      dneg_ff, dneg_in;
   logic [INTEG_W-1:0]        imag_ff, imag_in;
   logic                      ineg_ff, ineg_in;
   logic [DT_W-1:0]           rem_ff, rem_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic [MUL_P_W-1:0]        prod_ff, prod_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   // combinational helpers
   logic signed [ANGLE_W:0]   diff;
   logic signed [ANGLE_W:0]   err;
   logic [DT_W:0]             trial;
   logic                      trial_ge;
   logic [MUL_A_W-1:0]        mul_a;
   logic [GAIN_W-1:0]         mul_b;
   logic [DRIVE_W-1:0]        term;
   logic                      term_sub;
   logic                      fold_en;
   logic signed [32:0]        incr;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [DRIVE_W-1:0] lim_pos;
   logic signed [DRIVE_W-1:0] clamped;
   logic                      out_free;

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // input differences, taken at the accept cycle
   always_comb begin
      diff = {req_payload.measured_angle[ANGLE_W-1], req_payload.measured_angle}
           - {prev_angle_ff[ANGLE_W-1], prev_angle_ff};
      err  = {req_payload.target_angle[ANGLE_W-1], req_payload.target_angle}
           - {req_payload.measured_angle[ANGLE_W-1], req_payload.measured_angle};
   end

   // divider trial subtract
   always_comb begin
      trial    = {rem_ff, quo_ff[QUO_W-1]};
      trial_ge = (trial >= {1'b0, dt_ff});
   end

   // shared multiplier operand select
   always_comb begin
      case (step_ff)
         STEP_P_ISSUE: begin
            mul_a = {{(MUL_A_W-ANGLE_W){1'b0}}, emag_ff};
            mul_b = error_gain_ff;
         end
         STEP_R_LO: begin
            mul_a = quo_ff[MUL_A_W-1:0];
            mul_b = rate_gain_ff;
         end
         STEP_R_HI: begin
            mul_a = {{(2*MUL_A_W-QUO_W){1'b0}}, quo_ff[QUO_W-1:MUL_A_W]};
            mul_b = rate_gain_ff;
         end
         STEP_I_LO: begin
            mul_a = imag_ff[MUL_A_W-1:0];
            mul_b = integral_gain_ff;
         end
         STEP_I_HI: begin
            mul_a = imag_ff[INTEG_W-1:MUL_A_W];
            mul_b = integral_gain_ff;
         end
         STEP_INCR: begin
            mul_a = {{(MUL_A_W-ANGLE_W){1'b0}}, emag_ff};
            mul_b = {{(GAIN_W-DT_W){1'b0}}, dt_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // term folded into the drive sum; proportional and rate terms subtract
   always_comb begin
      fold_en  = 1'b0;
      term     = acc_ff[DRIVE_W+11:12];
      term_sub = 1'b0;
      case (step_ff)
         STEP_R_HI: begin
            fold_en  = 1'b1;
            term_sub = !eneg_ff;
         end
         STEP_I_HI: begin
            fold_en  = 1'b1;
            term_sub = !dneg_ff;
         end
         STEP_I_FOLD: begin
            fold_en  = 1'b1;
            term     = {{(DRIVE_W-(ACC_W-32)){1'b0}}, acc_ff[ACC_W-1:32]};
            term_sub = ineg_ff;
         end
         default: begin
            fold_en  = 1'b0;
         end
      endcase
   end

   // integral update and drive clamp for the final step
   always_comb begin
      incr      = eneg_ff ? -$signed({1'b0, acc_ff[31:0]}) : $signed({1'b0, acc_ff[31:0]});
      integ_sum = {integ_ff[INTEG_W-1], integ_ff} + {{(INTEG_W-32){incr[32]}}, incr};
      lim_pos   = $signed({{(DRIVE_W-LIMIT_W){1'b0}}, drive_limit_ff});
      if (drive_ff > lim_pos) begin
         clamped = lim_pos;
      end else if (drive_ff < -lim_pos) begin
         clamped = -lim_pos;
      end else begin
         clamped = drive_ff;
      end
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // sequencer and datapath next values
   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      step_in          = step_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_payload_in   = rsp_payload_ff;
      prev_angle_in    = prev_angle_ff;
      integ_in         = integ_ff;
      dt_in            = dt_ff;
      emag_in          = emag_ff;
      eneg_in          = eneg_ff;
      dneg_in          = dneg_ff;
      imag_in          = imag_ff;
      ineg_in          = ineg_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      prod_in          = mul_a * mul_b;
      acc_in           = acc_ff;
      drive_in         = drive_ff;
      error_gain_in    = error_gain_ff;
      rate_gain_in     = rate_gain_ff;
      integral_gain_in = integral_gain_ff;
      drive_limit_in   = drive_limit_ff;
      thrust_level_in  = thrust_level_ff;

      // response beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ERROR_GAIN:    error_gain_in    = csr_write_data[GAIN_W-1:0];
            CSR_RATE_GAIN:     rate_gain_in     = csr_write_data[GAIN_W-1:0];
            CSR_INTEGRAL_GAIN: integral_gain_in = csr_write_data[GAIN_W-1:0];
            CSR_DRIVE_LIMIT:   drive_limit_in   = csr_write_data[LIMIT_W-1:0];
            CSR_THRUST_LEVEL:  thrust_level_in  = csr_write_data[THRUST_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dt_in         = (req_payload.step_time == '0) ? DT_W'(1)
                                                            : req_payload.step_time;
               dneg_in       = diff[ANGLE_W];
               emag_in       = err[ANGLE_W] ? ANGLE_W'(-err) : err[ANGLE_W-1:0];
               eneg_in       = err[ANGLE_W];
               imag_in       = integ_ff[INTEG_W-1] ? (~integ_ff + 1'b1) : integ_ff;
               ineg_in       = integ_ff[INTEG_W-1];
               rem_in        = '0;
               quo_in        = {(diff[ANGLE_W] ? ANGLE_W'(-diff) : diff[ANGLE_W-1:0]),
                                {RATE_SHIFT{1'b0}}};
               prev_angle_in = req_payload.measured_angle;
               drive_in      = '0;
               cnt_in        = CNT_W'(QUO_W - 1);
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // one quotient bit per cycle
            rem_in = trial_ge ? DT_W'(trial - {1'b0, dt_ff}) : trial[DT_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], trial_ge};
            if (cnt_ff == '0) begin
               step_in  = STEP_P_ISSUE;
               state_in = ST_MULTIPLY;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_MULTIPLY: begin
            if (fold_en) begin
               drive_in = term_sub ? drive_ff - $signed(term) : drive_ff + $signed(term);
            end
            case (step_ff)
               STEP_R_LO, STEP_R_HI, STEP_I_HI, STEP_I_FOLD: begin
                  acc_in = {{(ACC_W-MUL_P_W){1'b0}}, prod_ff};
               end
               STEP_I_LO, STEP_INCR: begin
                  acc_in = acc_ff + {prod_ff, {MUL_A_W{1'b0}}};
               end
               default: ;
            endcase
            if (step_ff == STEP_FINISH) begin
               if (out_free) begin
                  if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
                     integ_in = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                                   : {1'b0, {(INTEG_W-1){1'b1}}};
                  end else begin
                     integ_in = integ_sum[INTEG_W-1:0];
                  end
                  rsp_payload_in.roll_drive   = clamped[ANGLE_W-1:0];
                  rsp_payload_in.thrust_drive = thrust_level_ff;
                  rsp_valid_in                = 1'b1;
                  state_in                    = ST_IDLE;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cnt_ff           <= '0;
         step_ff          <= STEP_P_ISSUE;
         rsp_valid_ff     <= 1'b0;
         prev_angle_ff    <= '0;
         integ_ff         <= '0;
         error_gain_ff    <= ERROR_GAIN_RST;
         rate_gain_ff     <= RATE_GAIN_RST;
         integral_gain_ff <= INTEGRAL_GAIN_RST;
         drive_limit_ff   <= DRIVE_LIMIT_RST;
         thrust_level_ff  <= THRUST_LEVEL_RST;
      end else begin
         state_ff         <= state_in;
         cnt_ff           <= cnt_in;
         step_ff          <= step_in;
         rsp_valid_ff     <= rsp_valid_in;
         prev_angle_ff    <= prev_angle_in;
         integ_ff         <= integ_in;
         error_gain_ff    <= error_gain_in;
         rate_gain_ff     <= rate_gain_in;
         integral_gain_ff <= integral_gain_in;
         drive_limit_ff   <= drive_limit_in;
         thrust_level_ff  <= thrust_level_in;
      end
   end

   // working registers, no reset
   always_ff @(posedge clock) begin
      dt_ff          <= dt_in;
      emag_ff        <= emag_in;
      eneg_ff        <= eneg_in;
      dneg_ff        <= dneg_in;
      imag_ff        <= imag_in;
      ineg_ff        <= ineg_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      drive_ff       <= drive_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule
`default_nettype wire

// ===== rtl/rapr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rapr_checker: port-level checks for the roll angle regulator
// Watches the beats on both channels; bound to the top level below.
// ----------------------------------------------------------------------------
module rapr_checker (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   input  wire                                 req_stall,
   input  wire                                 rsp_valid,
   input  wire                                 rsp_stall,
   input  rapr_pkg::rsp_payload_type           rsp_payload
);
   import rapr_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   // clamp is symmetric, so the most negative code never appears
   a_drive_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.roll_drive != {1'b1, {(ANGLE_W-1){1'b0}}})
      else $error("roll drive outside symmetric range");

   // an accepted request closes the request side while it is worked
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side open right after accept");

   // a new response only appears at the end of a busy period
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response beat without work");

endmodule

bind roll_angle_pid_regulator_unit rapr_checker u_rapr_checker (.*);
`default_nettype wire

// ===== test/roll_angle_pid_regulator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roll_angle_pid_regulator_unit_tb: self-checking bench for the roll regulator
// Drives angle beats through a short table, then several gain/limit settings
// with random angles and step times, plus a short full-error soak that winds
// up the error integral. Every response beat is compared against a bit-exact
// PID predictor kept inside the bench, or against the table's roll if typed.
// ----------------------------------------------------------------------------
module roll_angle_pid_regulator_unit_tb;
   import rapr_pkg::*;

   localparam int CYCLE_LIMIT  = 6_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_BEATS  = 150;
   localparam int SOAK_BEATS   = 24;

   // indexes that map to no register
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam longint INTEG_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint INTEG_LO = -64'sh0000_8000_0000_0000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_payload;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   roll_angle_pid_regulator_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // bench copy of registers and loop state
   logic [GAIN_W-1:0]   model_error_gain;
   logic [GAIN_W-1:0]   model_rate_gain;
   logic [GAIN_W-1:0]   model_integral_gain;
   logic [LIMIT_W-1:0]  model_drive_limit;
   logic [THRUST_W-1:0] model_thrust_level;
   longint              held_angle;
   longint              error_sum;

   rsp_payload_type drive_q[$];

   typedef struct {
      logic signed [ANGLE_W-1:0] measured;
      logic signed [ANGLE_W-1:0] target;
      logic        [DT_W-1:0]    step;
      bit                        typed;
      logic signed [ANGLE_W-1:0] roll;
   } angle_row_type;

   angle_row_type angle_rows[$];

   int  mismatch_count = 0;
   int  beats_sent     = 0;
   int  beats_checked  = 0;
   int  csr_writes     = 0;
   int  soak_count     = 0;
   int  cycle_count    = 0;
   bit  no_idle        = 0;
   bit  hold_off_request = 0;
   logic signed [ANGLE_W-1:0] last_measured = '0;

   // clock and cycle watchdog
   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  drive_q.size());
         $display("roll_angle_pid_regulator_unit_tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint unsigned magnitude(input longint a);
      return (a < 0) ? longint'(-a) : a;
   endfunction

   // a*g/2^12, truncated toward zero
   function automatic longint scale_q12(input longint a, input logic [GAIN_W-1:0] g);
      longint unsigned m;
      m = (magnitude(a) * g) >> 12;
      return (a < 0) ? -longint'(m) : longint'(m);
   endfunction

   // a*g/2^32, truncated toward zero; product needs more than 64 bits
   function automatic longint scale_q32(input longint a, input logic [GAIN_W-1:0] g);
      logic [127:0] p;
      p = magnitude(a);
      p = p * g;
      p = p >> 32;
      return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic rsp_payload_type predict_drive(input req_payload_type beat);
      longint meas, targ, diff, rate, err, drive, next, lim;
      longint unsigned dt, rmag;
      rsp_payload_type res;
      meas = $signed(beat.measured_angle);
      targ = $signed(beat.target_angle);
      dt   = (beat.step_time == '0) ? 1 : beat.step_time;
      // rate from the measurement change over the step
      diff = meas - held_angle;
      rmag = (magnitude(diff) << RATE_SHIFT) / dt;
      rate = (diff < 0) ? -longint'(rmag) : longint'(rmag);
      held_angle = meas;
      err = targ - meas;
      // drive uses the integral from before this step
      drive = -scale_q12(err, model_error_gain) - scale_q12(rate, model_rate_gain)
              + scale_q32(error_sum, model_integral_gain);
      next = error_sum + err * longint'(dt);
      if (next > INTEG_HI) next = INTEG_HI;
      if (next < INTEG_LO) next = INTEG_LO;
      error_sum = next;
      lim = longint'(model_drive_limit);
      if (drive > lim) drive = lim;
      else if (drive < -lim) drive = -lim;
      res.roll_drive   = drive[ANGLE_W-1:0];
      res.thrust_drive = model_thrust_level;
      return res;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("beat %0d: %s: got %0d, expected %0d", beats_checked, what, got, want);
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_q.size() == 0) begin
            report_mismatch("response beat with nothing outstanding",
                            $signed(rsp_payload.roll_drive), 0);
         end else begin
            want = drive_q.pop_front();
            if (rsp_payload.roll_drive !== want.roll_drive)
               report_mismatch("roll_drive", $signed(rsp_payload.roll_drive),
                               $signed(want.roll_drive));
            if (rsp_payload.thrust_drive !== want.thrust_drive)
               report_mismatch("thrust_drive", rsp_payload.thrust_drive,
                               want.thrust_drive);
            beats_checked++;
         end
      end
   end

   // ---------------------------------------------------------------- idling
   function automatic int idle_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 150);
   endfunction

   // response side stall, with one long hold-off on request
   initial begin : rsp_stall_driver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_left = HOLD_CYCLES;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_gap();
         end
      end
   end

   // ---------------------------------------------------------------- drivers
   // called and returns at a falling edge
   task automatic send_item(input req_payload_type beat, input bit typed,
                            input rsp_payload_type typed_want);
      int gap;
      rsp_payload_type want;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= beat;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = predict_drive(beat);
      drive_q.push_back(typed ? typed_want : want);
      beats_sent++;
      last_measured = beat.measured_angle;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         CSR_ERROR_GAIN:    model_error_gain    = data;
         CSR_RATE_GAIN:     model_rate_gain     = data;
         CSR_INTEGRAL_GAIN: model_integral_gain = data;
         CSR_DRIVE_LIMIT:   model_drive_limit   = data[LIMIT_W-1:0];
         CSR_THRUST_LEVEL:  model_thrust_level  = data[THRUST_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // request side goes quiet first, so the last beat is not taken twice
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (drive_q.size() != 0) @(negedge clock);
   endtask

   task automatic set_regs(input logic [CSR_DATA_W-1:0] eg, input logic [CSR_DATA_W-1:0] rg,
                           input logic [CSR_DATA_W-1:0] ig, input logic [CSR_DATA_W-1:0] lim,
                           input logic [CSR_DATA_W-1:0] thr);
      wait_drained();
      write_reg(CSR_ERROR_GAIN, eg);
      write_reg(CSR_RATE_GAIN, rg);
      write_reg(CSR_INTEGRAL_GAIN, ig);
      write_reg(CSR_DRIVE_LIMIT, lim);
      write_reg(CSR_THRUST_LEVEL, thr);
   endtask

   function automatic logic [ANGLE_W-1:0] pick_angle();
      logic [ANGLE_W-1:0] v;
      v = ANGLE_W'($urandom);
      case ($urandom_range(0, 9))
         0:       v = 16'h8000;
         1:       v = 16'h7FFF;
         2, 3:    v = 16'($urandom_range(0, 400)) - 16'd200;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [DT_W-1:0] pick_step();
      logic [DT_W-1:0] v;
      v = DT_W'($urandom);
      case ($urandom_range(0, 9))
         0:       v = '0;
         1:       v = 16'hFFFF;
         2, 3:    v = 16'($urandom_range(1, 64));
         default: ;
      endcase
      return v;
   endfunction

   task automatic random_beats(input int count);
      req_payload_type beat;
      rsp_payload_type unused;
      unused = '0;
      repeat (count) begin
         // sometimes hold the angle so the rate is zero
         beat.measured_angle = ($urandom_range(0, 9) == 0) ? last_measured : pick_angle();
         beat.target_angle   = ($urandom_range(0, 7) == 0) ? beat.measured_angle
                                                           : pick_angle();
         beat.step_time      = pick_step();
         send_item(beat, 1'b0, unused);
      end
   endtask

   task automatic add_row(input logic signed [ANGLE_W-1:0] measured,
                          input logic signed [ANGLE_W-1:0] target,
                          input logic [DT_W-1:0] step, input bit typed,
                          input logic signed [ANGLE_W-1:0] roll);
      angle_row_type row;
      row.measured = measured;
      row.target   = target;
      row.step     = step;
      row.typed    = typed;
      row.roll     = roll;
      angle_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin : stimulus
      req_payload_type beat;
      rsp_payload_type want;
      int i;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;

      model_error_gain    = ERROR_GAIN_RST;
      model_rate_gain     = RATE_GAIN_RST;
      model_integral_gain = INTEGRAL_GAIN_RST;
      model_drive_limit   = DRIVE_LIMIT_RST;
      model_thrust_level  = THRUST_LEVEL_RST;
      held_angle          = 0;
      error_sum           = 0;

      //       measured   target     step   typed  roll
      add_row(16'sd0,     16'sd0,     16'd1,     1, 16'sd0);     // fresh out of reset
      add_row(16'sd0,     16'sd0,     16'd0,     1, 16'sd0);     // zero step time
      add_row(16'sd0,     16'sd32767, 16'd65535, 1, -16'sd1229); // clamp low
      add_row(16'sd0,     16'sd0,     16'd1,     1, 16'sd1229);  // integral alone clamps
      add_row(16'sd0,    -16'sd32768, 16'd65535, 1, 16'sd1229);
      add_row(16'sd32767, 16'sd32767, 16'd1,     1, -16'sd1229); // rate jump up
      add_row(-16'sd32768,-16'sd32768,16'd1,     1, 16'sd1229);  // rate jump down
      add_row(-16'sd32768,-16'sd32768,16'd0,     0, 16'sd0);
      add_row(-16'sd32768,16'sd32767, 16'd65535, 0, 16'sd0);
      add_row(16'sd32767,-16'sd32768, 16'd65535, 0, 16'sd0);
      add_row(16'sd100,   16'sd120,   16'd3000,  0, 16'sd0);
      add_row(16'sd120,   16'sd90,    16'd2999,  0, 16'sd0);
      add_row(-16'sd5,   -16'sd5,     16'd65535, 0, 16'sd0);
      add_row(16'sd4096,  16'sd4097,  16'd0,     0, 16'sd0);
      add_row(-16'sd1,    16'sd1,     16'd32768, 0, 16'sd0);

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed table, reset register values
      for (i = 0; i < angle_rows.size(); i++) begin
         beat.measured_angle = angle_rows[i].measured;
         beat.target_angle   = angle_rows[i].target;
         beat.step_time      = angle_rows[i].step;
         want.roll_drive     = angle_rows[i].roll;
         want.thrust_drive   = THRUST_LEVEL_RST;
         send_item(beat, angle_rows[i].typed, want);
      end

      // reset values, with one full pause part way through
      random_beats(60);
      wait_drained();
      random_beats(PHASE_BEATS - 60);

      // gains and limit at their top, thrust at 4096; receiver holds off long enough to back up the input
      set_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'h07FFF, 20'd4096);
      hold_off_request = 1;
      random_beats(PHASE_BEATS);

      // everything at zero; spare indexes must not disturb anything
      set_regs('0, '0, '0, '0, '0);
      write_reg(CSR_SPARE_LO, 20'hFFFFF);
      write_reg(CSR_SPARE_HI, 20'h12345);
      random_beats(PHASE_BEATS);

      // random gains, limit written with junk above its width, thrust above range
      set_regs(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom), 20'hFFFFF);
      random_beats(PHASE_BEATS);

      // small gains, widest limit, no idling on either side
      set_regs(20'($urandom_range(0, 4096)), 20'($urandom_range(0, 4096)),
               20'($urandom_range(0, 4096)), 20'hFFFFF, 20'($urandom_range(0, 4096)));
      no_idle = 1;
      random_beats(PHASE_BEATS);

      // soak: full error every beat, the integral climbs by about 2^32 a beat;
      // with unit integral gain the drive shows the integral in Q.32
      set_regs('0, '0, 20'd1, 20'h07FFF, 20'd4096);
      beat.measured_angle = 16'sh8000;
      beat.target_angle   = 16'sh7FFF;
      beat.step_time      = 16'hFFFF;
      want = '0;
      repeat (SOAK_BEATS) begin
         send_item(beat, 1'b0, want);
         soak_count++;
      end
      no_idle = 0;

      // random everything, starting from a wound-up integral
      set_regs(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
               20'($urandom_range(0, 4096)));
      random_beats(PHASE_BEATS);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d angle beats, checked %0d drive beats, %0d register writes",
               beats_sent, beats_checked, csr_writes);
      $display("full-error soak ran %0d beats, %0d mismatches", soak_count,
               mismatch_count);
      if (mismatch_count == 0 && drive_q.size() == 0) begin
         $display("roll_angle_pid_regulator_unit_tb passed");
      end else begin
         $display("roll_angle_pid_regulator_unit_tb failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rapr_pkg.sv
rtl/roll_angle_pid_regulator_unit.sv
rtl/rapr_checker.sv
test/roll_angle_pid_regulator_unit_tb.sv
